// File: src/tbte_pkg.sv
package tbte_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int QUEUE_DEPTH   = 2;
    localparam int RETRY_W       = 4;
    localparam int KIND_W        = 5;
    localparam int FLAG_W        = 6;

    localparam logic [7:0] WAIT_INDEX = 8'hFF;

    // request modes
    localparam logic [1:0] MODE_BUS   = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // bus actions
    localparam logic [2:0] ACT_NOACK = 3'd0;
    localparam logic [2:0] ACT_ACK   = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_NONE  = 3'd4;

    // TWI status codes
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;
    localparam logic [7:0] ST_SR_SLA_ACK   = 8'h60;
    localparam logic [7:0] ST_SR_DATA_ACK  = 8'h80;
    localparam logic [7:0] ST_SR_STOP      = 8'hA0;
    localparam logic [7:0] ST_ST_SLA_ACK   = 8'hA8;
    localparam logic [7:0] ST_ST_ARB_SLA   = 8'hB0;
    localparam logic [7:0] ST_ST_DATA_ACK  = 8'hB8;
    localparam logic [7:0] ST_ST_DATA_NACK = 8'hC0;
    localparam logic [7:0] ST_ST_LAST_ACK  = 8'hC8;

    // request kinds after classification
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t K_MSEND_FIRST = 5'd0;
    localparam kind_t K_MSEND       = 5'd1;
    localparam kind_t K_MRX_DATA    = 5'd2;
    localparam kind_t K_MRX_ADDR    = 5'd3;
    localparam kind_t K_MRX_LAST    = 5'd4;
    localparam kind_t K_ARB         = 5'd5;
    localparam kind_t K_MFAIL       = 5'd6;
    localparam kind_t K_SADDR       = 5'd7;
    localparam kind_t K_SDATA       = 5'd8;
    localparam kind_t K_STX_END     = 5'd9;
    localparam kind_t K_SSTOP       = 5'd10;
    localparam kind_t K_STX_FIRST   = 5'd11;
    localparam kind_t K_STX         = 5'd12;
    localparam kind_t K_UNKNOWN     = 5'd13;
    localparam kind_t K_START       = 5'd14;
    localparam kind_t K_WRITE       = 5'd15;
    localparam kind_t K_READ        = 5'd16;

    // status flag masks
    localparam logic [FLAG_W-1:0] FL_BUSY  = 6'b000001;
    localparam logic [FLAG_W-1:0] FL_ERROR = 6'b000010;
    localparam logic [FLAG_W-1:0] FL_MTX   = 6'b000100;
    localparam logic [FLAG_W-1:0] FL_MRX   = 6'b001000;
    localparam logic [FLAG_W-1:0] FL_STX   = 6'b010000;
    localparam logic [FLAG_W-1:0] FL_SRX   = 6'b100000;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;      // bus byte or host byte
        logic [7:0] first;
        logic [7:0] end_idx;
        logic [7:0] swi;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [7:0]        send_byte;
        logic              send_valid;
        logic [FLAG_W-1:0] flags;
        logic [7:0]        rstart;
        logic [7:0]        rd;
    } result_t;

endpackage

// File: src/tbte_front.sv
module tbte_front
    import tbte_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] bus_status,
    input  logic [7:0] bus_data,
    input  logic [7:0] first_index,
    input  logic [7:0] end_index,
    input  logic [7:0] switch_index,
    input  logic [7:0] buffer_byte,
    input  logic       q_full,
    output logic       push,
    output cmd_t       cmd
);

    kind_t bus_kind;

    always_comb
    begin
        case (bus_status)
            ST_START, ST_RESTART:              bus_kind = K_MSEND_FIRST;
            ST_MT_SLA_ACK, ST_MT_DATA_ACK:     bus_kind = K_MSEND;
            ST_MR_DATA_ACK:                    bus_kind = K_MRX_DATA;
            ST_MR_SLA_ACK:                     bus_kind = K_MRX_ADDR;
            ST_MR_DATA_NACK:                   bus_kind = K_MRX_LAST;
            ST_ARB_LOST:                       bus_kind = K_ARB;
            ST_MR_SLA_NACK, ST_MT_SLA_NACK,
            ST_MT_DATA_NACK:                   bus_kind = K_MFAIL;
            ST_SR_SLA_ACK:                     bus_kind = K_SADDR;
            ST_SR_DATA_ACK:                    bus_kind = K_SDATA;
            ST_ST_DATA_NACK, ST_ST_LAST_ACK:   bus_kind = K_STX_END;
            ST_SR_STOP:                        bus_kind = K_SSTOP;
            ST_ST_SLA_ACK:                     bus_kind = K_STX_FIRST;
            ST_ST_ARB_SLA, ST_ST_DATA_ACK:     bus_kind = K_STX;
            default:                           bus_kind = K_UNKNOWN;
        endcase
    end

    always_comb
    begin
        cmd.first   = first_index;
        cmd.end_idx = end_index;
        cmd.swi     = switch_index;
        cmd.data    = bus_data;
        case (mode)
            MODE_BUS:   cmd.kind = bus_kind;
            MODE_START: cmd.kind = K_START;
            MODE_WRITE:
            begin
                cmd.kind = K_WRITE;
                cmd.data = buffer_byte;
            end
            default:    cmd.kind = K_READ;
        endcase
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

// File: src/tbte_queue.sv
module tbte_queue
    import tbte_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    output logic full,
    input  logic pop,
    output cmd_t cmd_out,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: src/tbte_back.sv
module tbte_back
    import tbte_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [RETRY_W-1:0] cfg_data,
    input  logic               q_empty,
    input  cmd_t               q_cmd,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output result_t            res
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam logic [7:0] DEPTH_B   = 8'(BUFFER_DEPTH);
    localparam logic [7:0] RSW_RESET = 8'(BUFFER_DEPTH + 1);

    localparam logic S_ISSUE = 1'b0;
    localparam logic S_EXEC  = 1'b1;

    logic               state_reg;
    cmd_t               cmd_reg;
    logic [7:0]         pos_reg, pos_next;
    logic [7:0]         start_reg, start_next;
    logic [7:0]         end_reg, end_next;
    logic [7:0]         rsw_reg, rsw_next;
    logic [7:0]         rstart_reg, rstart_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;
    logic [RETRY_W-1:0] retries_reg, retries_next;
    logic [RETRY_W-1:0] arb_cfg_reg;
    logic               out_valid_reg;
    result_t            res_reg;

    logic [7:0]              mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] vld_reg;
    logic [7:0]              rdata_reg;
    logic                    rd_ok_reg;

    // issue side
    logic [7:0]        p_issue;
    logic [7:0]        raddr;
    logic [ADDR_W-1:0] ridx;

    // execute side
    logic              commit;
    logic [7:0]        rbyte;
    logic [7:0]        p_send;
    logic [7:0]        pos_rx;
    logic [2:0]        act;
    logic [7:0]        tx;
    logic              txv;
    logic [7:0]        rd;
    logic              we;
    logic [7:0]        waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] widx;

    assign pop = (state_reg == S_ISSUE) && !q_empty;

    always_comb
    begin
        p_issue = (q_cmd.kind == K_MSEND_FIRST) ? start_reg : pos_reg;
        case (q_cmd.kind)
            K_MSEND_FIRST, K_MSEND: raddr = (p_issue == rsw_reg) ? start_reg : p_issue;
            K_STX_FIRST, K_STX:     raddr = (pos_reg >= DEPTH_B) ? 8'd0 : pos_reg;
            K_READ:                 raddr = q_cmd.first;
            default:                raddr = pos_reg;
        endcase
        ridx = raddr[ADDR_W-1:0];
    end

    assign commit = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign rbyte  = rd_ok_reg ? rdata_reg : 8'd0;

    always_comb
    begin
        pos_next     = pos_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        rsw_next     = rsw_reg;
        rstart_next  = rstart_reg;
        flags_next   = flags_reg;
        retries_next = retries_reg;
        act          = ACT_ACK;
        tx           = 8'd0;
        txv          = 1'b0;
        rd           = 8'd0;
        we           = 1'b0;
        waddr        = pos_reg;
        wdata        = cmd_reg.data;
        p_send       = (cmd_reg.kind == K_MSEND_FIRST) ? start_reg : pos_reg;
        pos_rx       = pos_reg;

        case (cmd_reg.kind)
            K_MSEND_FIRST, K_MSEND:
            begin
                pos_next = p_send;
                if (p_send == rsw_reg)
                begin
                    // raise the read bit of the address byte, repeated start
                    we       = (start_reg < DEPTH_B);
                    waddr    = start_reg;
                    wdata    = rbyte | 8'd1;
                    rsw_next = RSW_RESET;
                    act      = ACT_START;
                end
                else if (p_send < end_reg)
                begin
                    tx       = rbyte;
                    txv      = 1'b1;
                    pos_next = p_send + 8'd1;
                    act      = ACT_NOACK;
                end
                else
                begin
                    flags_next = (flags_reg & ~FL_BUSY) | FL_MTX;
                    act        = ACT_STOP;
                end
            end
            K_MRX_DATA, K_MRX_ADDR:
            begin
                if (cmd_reg.kind == K_MRX_ADDR)
                begin
                    rstart_next = pos_reg;
                end
                else if (pos_reg < DEPTH_B)
                begin
                    we     = 1'b1;
                    pos_rx = pos_reg + 8'd1;
                end
                pos_next = pos_rx;
                // ack while another byte follows the next one
                if (({1'b0, pos_rx} + 9'd1) < {1'b0, end_reg})
                begin
                    act = ACT_ACK;
                end
                else
                begin
                    flags_next = flags_reg | FL_MRX;
                    act        = ACT_NOACK;
                end
            end
            K_MRX_LAST:
            begin
                if (pos_reg < DEPTH_B)
                begin
                    we       = 1'b1;
                    pos_next = pos_reg + 8'd1;
                end
                flags_next = flags_reg & ~FL_BUSY;
                act        = ACT_STOP;
            end
            K_ARB:
            begin
                if (retries_reg != '0)
                begin
                    retries_next = retries_reg - 1'b1;
                    act          = ACT_START;
                end
                else
                begin
                    flags_next = FL_ERROR;
                end
            end
            K_MFAIL:
            begin
                flags_next = FL_ERROR;
                act        = ACT_STOP;
            end
            K_SADDR:
            begin
                pos_next   = WAIT_INDEX;
                flags_next = FL_BUSY;
            end
            K_SDATA:
            begin
                if (pos_reg == WAIT_INDEX)
                begin
                    pos_next    = cmd_reg.data;
                    rstart_next = cmd_reg.data;
                end
                else if (pos_reg < DEPTH_B)
                begin
                    we       = 1'b1;
                    pos_next = pos_reg + 8'd1;
                end
            end
            K_STX_END:
            begin
                flags_next = FL_STX;
            end
            K_SSTOP:
            begin
                flags_next = FL_SRX;
            end
            K_STX_FIRST, K_STX:
            begin
                if (cmd_reg.kind == K_STX_FIRST)
                begin
                    flags_next = FL_BUSY;
                end
                tx       = rbyte;
                txv      = 1'b1;
                pos_next = ((pos_reg >= DEPTH_B) ? 8'd0 : pos_reg) + 8'd1;
            end
            K_START:
            begin
                start_next   = cmd_reg.first;
                end_next     = cmd_reg.end_idx;
                rsw_next     = cmd_reg.swi;
                flags_next   = FL_BUSY;
                retries_next = arb_cfg_reg;
                act          = ACT_START;
            end
            K_WRITE:
            begin
                we    = (cmd_reg.first < DEPTH_B);
                waddr = cmd_reg.first;
                act   = ACT_NONE;
            end
            K_READ:
            begin
                rd  = rbyte;
                act = ACT_NONE;
            end
            default:
            begin
                flags_next = FL_ERROR;
            end
        endcase
        widx = waddr[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ISSUE;
            pos_reg       <= 8'd0;
            start_reg     <= 8'd0;
            end_reg       <= 8'd0;
            rsw_reg       <= RSW_RESET;
            rstart_reg    <= 8'd0;
            flags_reg     <= '0;
            retries_reg   <= '0;
            arb_cfg_reg   <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                arb_cfg_reg <= cfg_data;
            end
            if (pop)
            begin
                state_reg <= S_EXEC;
            end
            else if (commit)
            begin
                state_reg <= S_ISSUE;
            end
            if (commit)
            begin
                pos_reg       <= pos_next;
                start_reg     <= start_next;
                end_reg       <= end_next;
                rsw_reg       <= rsw_next;
                rstart_reg    <= rstart_next;
                flags_reg     <= flags_next;
                retries_reg   <= retries_next;
                out_valid_reg <= 1'b1;
                if (we)
                begin
                    vld_reg[widx] <= 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg   <= q_cmd;
            rdata_reg <= mem[ridx];
            rd_ok_reg <= (raddr < DEPTH_B) && vld_reg[ridx];
        end
        if (commit)
        begin
            res_reg <= '{action: act, send_byte: tx, send_valid: txv,
                         flags: flags_next, rstart: rstart_next, rd: rd};
            if (we)
            begin
                mem[widx] <= wdata;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// File: src/two_wire_bus_transfer_engine.sv
// Channel   Direction  Handshake             Content
// in        input      in_valid / in_stall   one request: mode, status, data, indexes, byte
// out       output     out_valid / out_stall one result: action, send byte, flags, indexes
// cfg       input      cfg_valid / cfg_ready arbitration retry count (4 bits)
//
// Requests are taken in every cycle while the two-entry request queue has room.
// The execute unit takes one request at a time: its issue state reads the byte
// buffer at an address set by the current position or the request's index, and its
// execute state updates state and writes back. Reset clears the control state and
// the buffer valid bits but not the buffer; entries read as zero until written.
// A stalled result stays in the output register while the next request executes up
// to its read; cfg_ready is always high.
module two_wire_bus_transfer_engine
    import tbte_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [7:0]         bus_status,
    input  logic [7:0]         bus_data,
    input  logic [7:0]         first_index,
    input  logic [7:0]         end_index,
    input  logic [7:0]         switch_index,
    input  logic [7:0]         buffer_byte,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         bus_action,
    output logic [7:0]         send_byte,
    output logic               send_valid,
    output logic               busy_flag,
    output logic               error_flag,
    output logic               master_sent_flag,
    output logic               master_received_flag,
    output logic               slave_sent_flag,
    output logic               slave_received_flag,
    output logic [7:0]         receive_start_index,
    output logic [7:0]         read_byte,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RETRY_W-1:0] cfg_data
);

    cmd_t    front_cmd;
    cmd_t    q_cmd;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    result_t res;

    // classify status codes and host commands
    tbte_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .bus_status   (bus_status),
        .bus_data     (bus_data),
        .first_index  (first_index),
        .end_index    (end_index),
        .switch_index (switch_index),
        .buffer_byte  (buffer_byte),
        .q_full       (q_full),
        .push         (push),
        .cmd          (front_cmd)
    );

    // decouples the request side from the execute unit
    tbte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .full    (q_full),
        .pop     (pop),
        .cmd_out (q_cmd),
        .empty   (q_empty)
    );

    // sequencer state, byte buffer and output register
    tbte_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res       (res)
    );

    assign cfg_ready = 1'b1;

    assign bus_action           = res.action;
    assign send_byte            = res.send_byte;
    assign send_valid           = res.send_valid;
    assign busy_flag            = res.flags[0];
    assign error_flag           = res.flags[1];
    assign master_sent_flag     = res.flags[2];
    assign master_received_flag = res.flags[3];
    assign slave_sent_flag      = res.flags[4];
    assign slave_received_flag  = res.flags[5];
    assign receive_start_index  = res.rstart;
    assign read_byte            = res.rd;

endmodule

// File: src/tbte_checker.sv
module tbte_checker
    import tbte_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] bus_action,
    input logic [7:0] send_byte,
    input logic       send_valid,
    input logic [7:0] receive_start_index,
    input logic [7:0] read_byte
);

    logic [3:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {3'd0, in_acc} - {3'd0, out_acc};
        end
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bus_action) && $stable(send_byte)
            && $stable(send_valid) && $stable(receive_start_index) && $stable(read_byte))
        else $error("stalled result changed");

    // no result without an earlier request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result without request");

    // buffer reads only come from host read requests
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_byte != 8'd0 |-> bus_action == ACT_NONE)
        else $error("read byte on bus event");

    // a loaded send byte goes with a continue action
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_valid |-> bus_action == ACT_NOACK || bus_action == ACT_ACK)
        else $error("send byte with wrong action");

endmodule

bind two_wire_bus_transfer_engine tbte_checker u_chk (.*);

// File: tb/sv/transfer_engine_checker.sv
module transfer_engine_checker
    import tbte_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [7:0]         bus_status,
    input  logic [7:0]         bus_data,
    input  logic [7:0]         first_index,
    input  logic [7:0]         end_index,
    input  logic [7:0]         switch_index,
    input  logic [7:0]         buffer_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         bus_action,
    input  logic [7:0]         send_byte,
    input  logic               send_valid,
    input  logic               busy_flag,
    input  logic               error_flag,
    input  logic               master_sent_flag,
    input  logic               master_received_flag,
    input  logic               slave_sent_flag,
    input  logic               slave_received_flag,
    input  logic [7:0]         receive_start_index,
    input  logic [7:0]         read_byte,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [RETRY_W-1:0] cfg_data,
    output int                 mismatches,
    output int                 outstanding,
    output int                 results_checked
);

    localparam int REPORT_LIMIT = 30;

    // shadow copy of the engine state
    logic [7:0]         buffer_mem [BUFFER_DEPTH];
    logic [7:0]         cursor;
    logic [7:0]         xfer_first;
    logic [7:0]         xfer_end;
    logic [7:0]         rx_switch;
    logic [7:0]         recv_origin;
    logic [FLAG_W-1:0]  flags;
    logic [RETRY_W-1:0] retries_left;
    logic [RETRY_W-1:0] retry_limit;

    result_t pending_results [$];
    result_t predicted;
    result_t oldest;

    function automatic logic [7:0] buffer_at(input logic [7:0] idx);
        return (idx < BUFFER_DEPTH) ? buffer_mem[idx] : 8'h00;
    endfunction

    // received byte goes to the cursor; dropped past the end of the buffer
    task automatic store_at_cursor(input logic [7:0] value);
        if (cursor < BUFFER_DEPTH)
        begin
            buffer_mem[cursor] = value;
            cursor = cursor + 8'd1;
        end
    endtask

    task automatic master_send(output logic [2:0] act, output logic [7:0] tx,
                               output logic txv);
        tx  = 8'h00;
        txv = 1'b0;
        if (cursor == rx_switch)
        begin
            // turn the address byte into a read and ask for a repeated start
            if (xfer_first < BUFFER_DEPTH)
                buffer_mem[xfer_first] = buffer_mem[xfer_first] | 8'h01;
            rx_switch = 8'(BUFFER_DEPTH + 1);
            act = ACT_START;
        end
        else if (cursor < xfer_end)
        begin
            tx     = buffer_at(cursor);
            txv    = 1'b1;
            cursor = cursor + 8'd1;
            act    = ACT_NOACK;
        end
        else
        begin
            flags = (flags & ~FL_BUSY) | FL_MTX;
            act   = ACT_STOP;
        end
    endtask

    // ack unless the next byte is the last one; no wrap in the compare
    task automatic master_ack_or_last(output logic [2:0] act);
        if ({1'b0, cursor} + 9'd1 < {1'b0, xfer_end})
            act = ACT_ACK;
        else
        begin
            flags = flags | FL_MRX;
            act   = ACT_NOACK;
        end
    endtask

    task automatic advance_engine(input logic [1:0] m, input logic [7:0] code,
                                  input logic [7:0] data, input logic [7:0] first,
                                  input logic [7:0] endi, input logic [7:0] swi,
                                  input logic [7:0] hbyte, output result_t r);
        logic [2:0] act;
        logic [7:0] tx;
        logic       txv;
        logic [7:0] rd;
        act = ACT_NONE;
        tx  = 8'h00;
        txv = 1'b0;
        rd  = 8'h00;
        case (m)
            MODE_BUS:
            begin
                case (code)
                    ST_START, ST_RESTART:
                    begin
                        cursor = xfer_first;
                        master_send(act, tx, txv);
                    end
                    ST_MT_SLA_ACK, ST_MT_DATA_ACK:
                        master_send(act, tx, txv);
                    ST_MR_DATA_ACK:
                    begin
                        store_at_cursor(data);
                        master_ack_or_last(act);
                    end
                    ST_MR_SLA_ACK:
                    begin
                        recv_origin = cursor;
                        master_ack_or_last(act);
                    end
                    ST_MR_DATA_NACK:
                    begin
                        store_at_cursor(data);
                        flags = flags & ~FL_BUSY;
                        act   = ACT_STOP;
                    end
                    ST_ARB_LOST:
                    begin
                        if (retries_left != '0)
                        begin
                            retries_left = retries_left - 1'b1;
                            act = ACT_START;
                        end
                        else
                        begin
                            flags = FL_ERROR;
                            act   = ACT_ACK;
                        end
                    end
                    ST_MR_SLA_NACK, ST_MT_SLA_NACK, ST_MT_DATA_NACK:
                    begin
                        flags = FL_ERROR;
                        act   = ACT_STOP;
                    end
                    ST_SR_SLA_ACK:
                    begin
                        cursor = WAIT_INDEX;
                        flags  = FL_BUSY;
                        act    = ACT_ACK;
                    end
                    ST_SR_DATA_ACK:
                    begin
                        // first byte after the address is the start index
                        if (cursor == WAIT_INDEX)
                        begin
                            cursor      = data;
                            recv_origin = data;
                        end
                        else
                            store_at_cursor(data);
                        act = ACT_ACK;
                    end
                    ST_ST_DATA_NACK, ST_ST_LAST_ACK:
                    begin
                        flags = FL_STX;
                        act   = ACT_ACK;
                    end
                    ST_SR_STOP:
                    begin
                        flags = FL_SRX;
                        act   = ACT_ACK;
                    end
                    ST_ST_SLA_ACK, ST_ST_ARB_SLA, ST_ST_DATA_ACK:
                    begin
                        if (code == ST_ST_SLA_ACK)
                            flags = FL_BUSY;
                        if (cursor >= BUFFER_DEPTH)
                            cursor = 8'd0;
                        tx     = buffer_mem[cursor];
                        txv    = 1'b1;
                        cursor = cursor + 8'd1;
                        act    = ACT_ACK;
                    end
                    default:
                    begin
                        flags = FL_ERROR;
                        act   = ACT_ACK;
                    end
                endcase
            end
            MODE_START:
            begin
                xfer_first   = first;
                xfer_end     = endi;
                rx_switch    = swi;
                flags        = FL_BUSY;
                retries_left = retry_limit;
                act          = ACT_START;
            end
            MODE_WRITE:
            begin
                if (first < BUFFER_DEPTH)
                    buffer_mem[first] = hbyte;
            end
            default:
                rd = buffer_at(first);
        endcase
        r.action     = act;
        r.send_byte  = txv ? tx : 8'h00;
        r.send_valid = txv;
        r.flags      = flags;
        r.rstart     = recv_origin;
        r.rd         = rd;
    endtask

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] seen);
        if (seen !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, what,
                         want, seen);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUFFER_DEPTH; i++)
                buffer_mem[i] = 8'h00;
            cursor          = 8'd0;
            xfer_first      = 8'd0;
            xfer_end        = 8'd0;
            rx_switch       = 8'(BUFFER_DEPTH + 1);
            recv_origin     = 8'd0;
            flags           = '0;
            retries_left    = '0;
            retry_limit     = '0;
            pending_results.delete();
            mismatches      = 0;
            outstanding     = 0;
            results_checked = 0;
        end
        else
        begin
            // compare before taking a new request: a result never belongs to
            // a request accepted at the same edge
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, got action %0d",
                                 $time, bus_action);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("bus_action", 8'(oldest.action), 8'(bus_action));
                    check_field("send_byte", oldest.send_byte, send_byte);
                    check_field("send_valid", 8'(oldest.send_valid), 8'(send_valid));
                    check_field("busy_flag", 8'(oldest.flags[0]), 8'(busy_flag));
                    check_field("error_flag", 8'(oldest.flags[1]), 8'(error_flag));
                    check_field("master_sent_flag", 8'(oldest.flags[2]),
                                8'(master_sent_flag));
                    check_field("master_received_flag", 8'(oldest.flags[3]),
                                8'(master_received_flag));
                    check_field("slave_sent_flag", 8'(oldest.flags[4]),
                                8'(slave_sent_flag));
                    check_field("slave_received_flag", 8'(oldest.flags[5]),
                                8'(slave_received_flag));
                    check_field("receive_start_index", oldest.rstart, receive_start_index);
                    check_field("read_byte", oldest.rd, read_byte);
                    results_checked++;
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_engine(mode, bus_status, bus_data, first_index, end_index,
                               switch_index, buffer_byte, predicted);
                pending_results.push_back(predicted);
            end
            if (cfg_valid && cfg_ready)
                retry_limit = cfg_data;
            outstanding = pending_results.size();
        end
    end

endmodule

// File: tb/sv/two_wire_bus_transfer_engine_tb.sv
// Top of the transfer engine bench. This module only makes stimulus and gives
// the verdict; prediction and comparison live in transfer_engine_checker,
// which watches the same wires as the engine.
module two_wire_bus_transfer_engine_tb;
    import tbte_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int DEPTH           = DEPTH_DEFAULT;
    localparam int HOLD_OFF_CYCLES = 80;
    // settle time past the last result: the engine registers each result, so
    // anything stray shows up well within this
    localparam int SETTLE_CYCLES   = 8;
    // watchdog limit, set well above the slowest correct run
    localparam int WATCHDOG_CYCLES = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [7:0]         bus_status;
    logic [7:0]         bus_data;
    logic [7:0]         first_index;
    logic [7:0]         end_index;
    logic [7:0]         switch_index;
    logic [7:0]         buffer_byte;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         bus_action;
    logic [7:0]         send_byte;
    logic               send_valid;
    logic               busy_flag;
    logic               error_flag;
    logic               master_sent_flag;
    logic               master_received_flag;
    logic               slave_sent_flag;
    logic               slave_received_flag;
    logic [7:0]         receive_start_index;
    logic [7:0]         read_byte;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [RETRY_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int results_checked;

    // 0 turns idling off on both sides; otherwise a 1-in-N chance per request
    // (sender) or per cycle (receiver) to start an idle burst
    int gap_odds = 0;
    bit hold_off_req = 1'b0;

    int sent        = 0;
    int bus_sent    = 0;
    int start_sent  = 0;
    int write_sent  = 0;
    int read_sent   = 0;
    int cfg_writes  = 0;

    two_wire_bus_transfer_engine dut (.*);

    transfer_engine_checker transfer_check (.*);

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(WATCHDOG_CYCLES * 2 * HALF_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side. Random stall bursts, quiet stretches, and on request one
    // long hold-off so the engine's queue fills and it pushes back on input.
    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (gap_odds != 0 && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(8, 40)) @(posedge clk);
        end
    end

    // Present one request and hold it until accepted. Called on a rising edge;
    // returns on the edge of acceptance, possibly after an idle burst.
    task automatic issue(input logic [1:0] m, input logic [7:0] code,
                         input logic [7:0] data, input logic [7:0] first,
                         input logic [7:0] endi, input logic [7:0] swi,
                         input logic [7:0] hbyte);
        mode         <= m;
        bus_status   <= code;
        bus_data     <= data;
        first_index  <= first;
        end_index    <= endi;
        switch_index <= swi;
        buffer_byte  <= hbyte;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        case (m)
            MODE_BUS:   bus_sent++;
            MODE_START: start_sent++;
            MODE_WRITE: write_sent++;
            default:    read_sent++;
        endcase
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // fields a request does not use still get random values
    task automatic bus_event(input logic [7:0] code, input logic [7:0] data);
        issue(MODE_BUS, code, data, 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
    endtask

    task automatic host_start(input logic [7:0] first, input logic [7:0] endi,
                              input logic [7:0] swi);
        issue(MODE_START, 8'($urandom), 8'($urandom), first, endi, swi, 8'($urandom));
    endtask

    task automatic host_write(input logic [7:0] addr, input logic [7:0] value);
        issue(MODE_WRITE, 8'($urandom), 8'($urandom), addr, 8'($urandom),
              8'($urandom), value);
    endtask

    task automatic host_read(input logic [7:0] addr);
        issue(MODE_READ, 8'($urandom), 8'($urandom), addr, 8'($urandom),
              8'($urandom), 8'($urandom));
    endtask

    // buffer index: mostly inside, with both ends and the range past the end
    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'(DEPTH - 1);
            2:       return 8'($urandom_range(DEPTH, 255));
            default: return 8'($urandom_range(0, DEPTH - 1));
        endcase
    endfunction

    // Sender pause: drop valid and wait until every result is back.
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called while the engine is idle
    task automatic write_retries(input logic [RETRY_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly well-formed bus conversations with random content: master
    // send-then-receive transfers, slave receives and slave transmits, plus
    // host buffer traffic and fully random requests as noise.
    task automatic run_mixed_traffic(input int count);
        int         stop_at;
        logic [7:0] first;
        logic [7:0] endi;
        logic [7:0] swi;
        logic [7:0] code;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    first = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, DEPTH - 8));
                    endi = first + 8'($urandom_range(0, 8));
                    case ($urandom_range(0, 3))
                        0:       swi = 8'($urandom);
                        1:       swi = 8'(DEPTH + 1);
                        default: swi = first + 8'($urandom_range(0, 6));
                    endcase
                    host_start(first, endi, swi);
                    bus_event(($urandom_range(0, 3) == 0) ? ST_RESTART : ST_START,
                              8'($urandom));
                    repeat ($urandom_range(1, 10))
                    begin
                        case ($urandom_range(0, 15))
                            0:       code = ST_ARB_LOST;
                            1:       code = ST_MT_DATA_NACK;
                            2:       code = ST_MT_SLA_NACK;
                            3:       code = ST_START;
                            4:       code = ST_MT_SLA_ACK;
                            default: code = ST_MT_DATA_ACK;
                        endcase
                        bus_event(code, 8'($urandom));
                    end
                    // receive half after the repeated start
                    if ($urandom_range(0, 2) != 0)
                    begin
                        bus_event(ST_RESTART, 8'($urandom));
                        bus_event(($urandom_range(0, 7) == 0) ? ST_MR_SLA_NACK
                                                              : ST_MR_SLA_ACK,
                                  8'($urandom));
                        repeat ($urandom_range(0, 8))
                            bus_event(ST_MR_DATA_ACK, 8'($urandom));
                        bus_event(ST_MR_DATA_NACK, 8'($urandom));
                    end
                end
                3, 4:
                begin
                    bus_event(ST_SR_SLA_ACK, 8'($urandom));
                    bus_event(ST_SR_DATA_ACK,
                              ($urandom_range(0, 7) == 0) ? WAIT_INDEX : pick_index());
                    repeat ($urandom_range(0, 10))
                        bus_event(ST_SR_DATA_ACK, 8'($urandom));
                    bus_event(ST_SR_STOP, 8'($urandom));
                end
                5, 6:
                begin
                    bus_event(($urandom_range(0, 3) == 0) ? ST_ST_ARB_SLA : ST_ST_SLA_ACK,
                              8'($urandom));
                    repeat ($urandom_range(0, 10))
                        bus_event(ST_ST_DATA_ACK, 8'($urandom));
                    bus_event(($urandom_range(0, 1) == 0) ? ST_ST_DATA_NACK
                                                          : ST_ST_LAST_ACK,
                              8'($urandom));
                end
                7:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            host_write(pick_index(), 8'($urandom));
                        else
                            host_read(pick_index());
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                        issue(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        mode         <= MODE_BUS;
        bus_status   <= 8'h00;
        bus_data     <= 8'h00;
        first_index  <= 8'h00;
        end_index    <= 8'h00;
        switch_index <= 8'h00;
        buffer_byte  <= 8'h00;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, two retries allowed.
        write_retries(4'd2);
        gap_odds = 4;
        host_read(8'd0);                    // never written, reads zero
        host_write(8'd0, 8'hFF);
        host_write(8'(DEPTH - 1), 8'h80);
        host_write(8'd255, 8'h5A);          // past the buffer: dropped
        host_read(8'd255);                  // past the buffer: zero
        // master sends two bytes, switches to receive at index 2
        host_start(8'd0, 8'd3, 8'd2);
        bus_event(ST_START, 8'h00);
        bus_event(ST_MT_SLA_ACK, 8'h00);
        bus_event(ST_MT_DATA_ACK, 8'h00);   // read bit set, repeated start
        bus_event(ST_RESTART, 8'h00);
        bus_event(ST_MR_SLA_ACK, 8'h00);
        bus_event(ST_MR_DATA_ACK, 8'h3C);
        bus_event(ST_MR_DATA_NACK, 8'hC3);
        // arbitration: two retries, then error
        repeat (3) bus_event(ST_ARB_LOST, 8'h00);
        bus_event(ST_MT_SLA_NACK, 8'h00);
        // slave receive starting near the end; the last byte falls off
        bus_event(ST_SR_SLA_ACK, 8'h00);
        bus_event(ST_SR_DATA_ACK, 8'(DEPTH - 2));
        bus_event(ST_SR_DATA_ACK, 8'hE7);
        bus_event(ST_SR_DATA_ACK, 8'h18);
        bus_event(ST_SR_DATA_ACK, 8'h99);
        bus_event(ST_SR_STOP, 8'h00);
        // slave transmit wraps to index 0
        bus_event(ST_ST_SLA_ACK, 8'h00);
        bus_event(ST_ST_LAST_ACK, 8'h00);
        bus_event(8'h09, 8'h00);            // unhandled code with low bits set
        // last-byte compare must not wrap at end index 255
        host_start(8'd254, 8'd255, 8'd200);
        bus_event(ST_START, 8'h00);
        bus_event(ST_MR_SLA_ACK, 8'h00);
        wait_results();

        // No retries allowed.
        write_retries(4'd0);
        gap_odds = 5;
        run_mixed_traffic(450);
        wait_results();

        // Most retries; open with a long output hold-off while requests keep coming.
        write_retries(4'd15);
        gap_odds = 0;
        hold_off_req = 1'b1;
        run_mixed_traffic(24);
        gap_odds = 3;
        run_mixed_traffic(430);
        wait_results();

        // Random retry count under heavy idling on both sides.
        write_retries(RETRY_W'($urandom_range(1, 14)));
        gap_odds = 2;
        run_mixed_traffic(450);
        wait_results();

        // Closing stretch at full rate.
        write_retries(4'd1);
        gap_odds = 0;
        run_mixed_traffic(500);
        wait_results();

        $write("Covered %0d requests: %0d bus events, %0d master starts, ",
               sent, bus_sent, start_sent);
        $display("%0d buffer writes, %0d buffer reads", write_sent, read_sent);
        $display("Checked %0d results across %0d retry settings, with one long output hold-off",
                 results_checked, cfg_writes);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
